// File: hw/rtl/tcsw_pkg.sv
// Shared types and constants for the text console scroll writer.
package tcsw_pkg;

	localparam logic [7:0] CH_NEWLINE       = 8'd10;
	localparam logic [7:0] CH_SPACE         = 8'd32;
	localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_in;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_color;
		logic [6:0] cursor_col;
		logic       did_scroll;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_PUTC,
		ST_READ,
		ST_RESP
	} state_t;

endpackage

// File: hw/rtl/tcsw_cell_ram.sv
// Single-port-write, registered-read cell memory for the screen store.
module tcsw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// Write one cell per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/text_console_scroll_writer_top.sv
// Top level of the text console scroll writer.
//
// Usage: drive item and raise start; the item is taken at the clock edge
// where start is high and busy is low. Each item yields one result, shown on
// result for exactly one cycle with result_valid high; the receiver cannot
// stall it. cfg_we / cfg_wdata set the text color and may be written while
// the block is idle.
// Steps from the transfer to the result strobe:
//   plain character write : decode, then cell write
//   cell read             : decode, memory read, then response
//   newline               : decode, then blank fill of the new bottom row
//   line wrap             : decode, blank fill, then cell write; the bottom row is refilled
//                           with blanks one cell a cycle by the fill counter.
// busy falls in the strobe cycle, so the next transfer can be taken at the
// edge that ends it; no new item is taken while one is still in progress.
// Rows form a ring in the cell memory, so a scroll only moves the top-row
// pointer; the blank fill of the new bottom row sets the scroll time.
// After reset the block runs a clearing pass over all LINE_COUNT * LINE_WIDTH
// cells (2000 by default), one cell a cycle, with busy high; configuration
// writes are taken during it. The receiver cannot stall, so results never
// back up.
module text_console_scroll_writer_top #(
	parameter int LINE_WIDTH = 80,
	parameter int LINE_COUNT = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcsw_pkg::item_t  item,
	output logic             result_valid,
	output tcsw_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);
	import tcsw_pkg::*;

	localparam int DEPTH = LINE_COUNT * LINE_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int CW    = $clog2(LINE_WIDTH + 1);

	state_t        state_q, state_d;
	item_t         req_q;
	result_t       result_q;
	logic          result_valid_q;
	logic [RW-1:0] top_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] addr_q;
	logic          pend_q;
	logic          scrolled_q;
	logic          rng_q;
	logic [7:0]    color_q;

	logic          we_c;
	logic [AW-1:0] waddr_c;
	logic [15:0]   wdata_c;
	logic [15:0]   rdata;

	logic [8:0]    row_sum_c;
	logic [8:0]    phys_row_c;
	logic [AW-1:0] read_addr_c;
	logic          rng_c;
	logic [RW-1:0] top_next_c;
	logic [RW-1:0] bottom_c;
	logic [AW-1:0] putc_addr_c;
	logic          scroll_c;
	logic          fill_last_c;

	// Map logical rows onto the ring of physical rows
	always_comb begin
		row_sum_c   = 9'(top_q) + 9'(req_q.read_row);
		phys_row_c  = (row_sum_c >= 9'(LINE_COUNT)) ? row_sum_c - 9'(LINE_COUNT) : row_sum_c;
		read_addr_c = AW'(32'(phys_row_c) * LINE_WIDTH + 32'(req_q.read_col));
		rng_c       = (8'(req_q.read_row) < 8'(LINE_COUNT))
		              && (9'(req_q.read_col) < 9'(LINE_WIDTH));
		top_next_c  = (top_q == RW'(LINE_COUNT - 1)) ? '0 : top_q + 1'b1;
		bottom_c    = (top_q == '0) ? RW'(LINE_COUNT - 1) : top_q - 1'b1;
		putc_addr_c = AW'(32'(bottom_c) * LINE_WIDTH + 32'(col_q));
		scroll_c    = (req_q.char_in == CH_NEWLINE) || (col_q == CW'(LINE_WIDTH));
		fill_last_c = (cnt_q == CW'(LINE_WIDTH - 1));
	end

	// Sequence next state and memory write port
	always_comb begin
		state_d = state_q;
		we_c    = 1'b0;
		waddr_c = addr_q;
		wdata_c = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we_c = 1'b1;
				if (addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (req_q.cmd == CMD_READ) begin
					state_d = ST_READ;
				end else if (scroll_c) begin
					state_d = ST_FILL;
				end else begin
					state_d = ST_PUTC;
				end
			end
			ST_FILL: begin
				we_c    = 1'b1;
				wdata_c = {color_q, CH_SPACE};
				if (fill_last_c) begin
					state_d = pend_q ? ST_PUTC : ST_IDLE;
				end
			end
			ST_PUTC: begin
				we_c    = 1'b1;
				waddr_c = putc_addr_c;
				wdata_c = {color_q, req_q.char_in};
				state_d = ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance control state, pointers and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			result_valid_q <= 1'b0;
			top_q          <= '0;
			col_q          <= '0;
			addr_q         <= '0;
			pend_q         <= 1'b0;
			color_q        <= TEXT_COLOR_RESET;
		end else begin
			state_q        <= state_d;
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CLEAR, ST_FILL: begin
					addr_q <= addr_q + 1'b1;
					if (state_q == ST_FILL && fill_last_c && !pend_q) begin
						result_valid_q <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (req_q.cmd == CMD_READ) begin
						addr_q <= rng_c ? read_addr_c : '0;
					end else if (scroll_c) begin
						// old top row becomes the new bottom row
						top_q  <= top_next_c;
						col_q  <= '0;
						addr_q <= AW'(32'(top_q) * LINE_WIDTH);
						pend_q <= (req_q.char_in != CH_NEWLINE);
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_PUTC: begin
					col_q          <= col_q + 1'b1;
					result_valid_q <= 1'b1;
				end
				ST_RESP: begin
					result_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the item and build the result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q <= item;
				end
			end
			ST_DECODE: begin
				scrolled_q <= (req_q.cmd == CMD_WRITE) && scroll_c;
				rng_q      <= rng_c;
				cnt_q      <= '0;
			end
			ST_FILL: begin
				cnt_q <= cnt_q + 1'b1;
				if (fill_last_c && !pend_q) begin
					result_q <= '{cell_char: '0, cell_color: '0,
					              cursor_col: '0, did_scroll: 1'b1};
				end
			end
			ST_PUTC: begin
				result_q <= '{cell_char: '0, cell_color: '0,
				              cursor_col: 7'(col_q + 1'b1), did_scroll: scrolled_q};
			end
			ST_RESP: begin
				result_q <= '{cell_char: rng_q ? rdata[7:0] : 8'd0,
				              cell_color: rng_q ? rdata[15:8] : 8'd0,
				              cursor_col: 7'(col_q), did_scroll: 1'b0};
			end
			default: begin
			end
		endcase
	end

	tcsw_cell_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_cell_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
